/* design/bqc_pkg.sv */
// Shared types and constants for the biquad cascade filter unit.
// No dependencies.
package bqc_pkg;

  localparam int COEF_BITS = 18;
  localparam int FF_BITS   = 3 * COEF_BITS;
  localparam int FB_BITS   = 2 * COEF_BITS;
  localparam int CFG_W     = FF_BITS;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_BITS  = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [FF_BITS-1:0]   ff_coef_t;
  typedef logic [FB_BITS-1:0]   fb_coef_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  localparam cfg_idx_t CFG_S1_FF = 2'd0;
  localparam cfg_idx_t CFG_S1_FB = 2'd1;
  localparam cfg_idx_t CFG_S2_FF = 2'd2;
  localparam cfg_idx_t CFG_S2_FB = 2'd3;

endpackage

/* design/biquad_cascade_iir_filter_unit.sv */
// Top level of the two-section biquad cascade: coefficient registers,
// input/result handshake and output saturation. Depends on bqc_pkg, bqc_cell.
//
//  channel   ports                                   direction
//  input     in_valid in_stall in_sample_in in_bypass   in (in_stall out)
//  result    out_valid out_stall out_sample_out         out (out_stall in)
//  config    cfg_we cfg_index cfg_data                  in
//
// From an input transfer to the result, each cell forms its five products in
// turn through its single multiplier, then hands its result onward.
// One item at a time; the next is taken while the last result waits.
// Reset clears coefficients to unity pass-through and the cells' s1/s2 state registers.
// A stalled result holds in the output register; a finished one waits behind it.
module biquad_cascade_iir_filter_unit #(
  parameter int SAMPLE_BITS    = 14,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample_in,
  input  logic                    in_bypass,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                    cfg_we,
  input  bqc_pkg::cfg_idx_t       cfg_index,
  input  bqc_pkg::cfg_data_t      cfg_data
);
  import bqc_pkg::*;

  localparam int XW = SAMPLE_BITS + 4;
  localparam logic signed [XW-1:0] OMAX = XW'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [XW-1:0] OMIN = ~OMAX;

  ff_coef_t                 s1_ff_r, s2_ff_r;
  fb_coef_t                 s1_fb_r, s2_fb_r;
  logic                     busy_r, go_r, pend_r, out_valid_r, bypass_r;
  logic [SAMPLE_BITS-1:0]   code_r, out_r;

  logic                     accept, pend, load;
  logic signed [XW-1:0]     x0, y1, y2, y_clamp;
  logic                     done1, done2;
  logic [SAMPLE_BITS-1:0]   filt;

  assign accept = in_valid && !busy_r;
  assign x0     = XW'($signed({~code_r[SAMPLE_BITS-1], code_r[SAMPLE_BITS-2:0]}));
  assign pend   = pend_r || done2;
  assign load   = pend && (!out_valid_r || !out_stall);

  bqc_cell #(.XW(XW), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cell1 (
    .clk(clk), .rst_n(rst_n), .ff_coef(s1_ff_r), .fb_coef(s1_fb_r),
    .start(go_r), .x_in(x0), .done(done1), .y_out(y1)
  );

  bqc_cell #(.XW(XW), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cell2 (
    .clk(clk), .rst_n(rst_n), .ff_coef(s2_ff_r), .fb_coef(s2_fb_r),
    .start(done1), .x_in(y1), .done(done2), .y_out(y2)
  );

  assign y_clamp = (y2 > OMAX) ? OMAX : (y2 < OMIN) ? OMIN : y2;
  assign filt    = {~y_clamp[SAMPLE_BITS-1], y_clamp[SAMPLE_BITS-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ff_r     <= FF_BITS'(1) << COEF_FRAC_BITS;
      s2_ff_r     <= FF_BITS'(1) << COEF_FRAC_BITS;
      s1_fb_r     <= '0;
      s2_fb_r     <= '0;
      busy_r      <= 1'b0;
      go_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_S1_FF: s1_ff_r <= cfg_data[FF_BITS-1:0];
          CFG_S1_FB: s1_fb_r <= cfg_data[FB_BITS-1:0];
          CFG_S2_FF: s2_ff_r <= cfg_data[FF_BITS-1:0];
          CFG_S2_FB: s2_fb_r <= cfg_data[FB_BITS-1:0];
          default: ;
        endcase
      end
      go_r <= accept;
      if (accept) begin
        code_r   <= in_sample_in;
        bypass_r <= in_bypass;
        busy_r   <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      pend_r <= pend && !load;
      if (load) begin
        out_r       <= bypass_r ? code_r : filt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall       = busy_r;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

endmodule

/* design/bqc_cell.sv */
// One transposed direct form II second-order section with a shared multiplier.
// Depends on bqc_pkg.
module bqc_cell #(
  parameter int XW             = 18,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bqc_pkg::ff_coef_t     ff_coef,
  input  bqc_pkg::fb_coef_t     fb_coef,
  input  logic                  start,
  input  logic signed [XW-1:0]  x_in,
  output logic                  done,
  output logic signed [XW-1:0]  y_out
);
  import bqc_pkg::*;

  localparam int PW = XW + COEF_BITS;
  localparam int AW = ((PW > ACC_BITS) ? PW : ACC_BITS) + 2;
  localparam logic signed [AW-1:0] HALF = AW'(2 ** (COEF_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] YMAX = AW'(2 ** (XW - 1) - 1);
  localparam logic signed [AW-1:0] YMIN = ~YMAX;
  localparam logic signed [AW-1:0] SMAX = AW'(2 ** (ACC_BITS - 1) - 1);
  localparam logic signed [AW-1:0] SMIN = ~SMAX;

  typedef enum logic [2:0] {
    ST_IDLE, ST_B0, ST_Y, ST_S1A, ST_S1B, ST_S2A, ST_S2B
  } step_t;

  step_t                       state_r;
  logic                        done_r;
  logic signed [XW-1:0]        x_r;
  logic signed [XW-1:0]        y_r;
  logic signed [PW-1:0]        prod_r;
  logic signed [AW-1:0]        acc_r;
  logic signed [ACC_BITS-1:0]  s1_r;
  logic signed [ACC_BITS-1:0]  s2_r;

  coef_t                       b0, b1, b2, a1, a2;
  logic signed [XW-1:0]        mul_a;
  coef_t                       mul_b;
  logic signed [AW-1:0]        full;
  logic signed [AW-1:0]        y_wide;
  logic signed [XW-1:0]        y_sat;
  logic signed [AW-1:0]        diff;
  logic signed [ACC_BITS-1:0]  diff_sat;

  assign b0 = ff_coef[COEF_BITS-1:0];
  assign b1 = ff_coef[2*COEF_BITS-1:COEF_BITS];
  assign b2 = ff_coef[3*COEF_BITS-1:2*COEF_BITS];
  assign a1 = fb_coef[COEF_BITS-1:0];
  assign a2 = fb_coef[2*COEF_BITS-1:COEF_BITS];

  always_comb begin
    mul_a = x_r;
    mul_b = b0;
    case (state_r)
      ST_Y:    mul_b = b1;
      ST_S1A: begin
        mul_a = y_r;
        mul_b = a1;
      end
      ST_S1B:  mul_b = b2;
      ST_S2A: begin
        mul_a = y_r;
        mul_b = a2;
      end
      default: mul_b = b0;
    endcase
  end

  assign full   = AW'(prod_r) + AW'(s1_r) + HALF;
  assign y_wide = full >>> COEF_FRAC_BITS;
  assign y_sat  = (y_wide > YMAX) ? YMAX[XW-1:0] :
                  (y_wide < YMIN) ? YMIN[XW-1:0] : y_wide[XW-1:0];

  assign diff     = acc_r - AW'(prod_r);
  assign diff_sat = (diff > SMAX) ? SMAX[ACC_BITS-1:0] :
                    (diff < SMIN) ? SMIN[ACC_BITS-1:0] : diff[ACC_BITS-1:0];

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      s1_r    <= '0;
      s2_r    <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            x_r     <= x_in;
            state_r <= ST_B0;
          end
        end
        ST_B0:  state_r <= ST_Y;
        ST_Y: begin
          y_r     <= y_sat;
          state_r <= ST_S1A;
        end
        ST_S1A: begin
          acc_r   <= AW'(prod_r) + AW'(s2_r);
          state_r <= ST_S1B;
        end
        ST_S1B: begin
          s1_r    <= diff_sat;
          state_r <= ST_S2A;
        end
        ST_S2A: begin
          acc_r   <= AW'(prod_r);
          state_r <= ST_S2B;
        end
        ST_S2B: begin
          s2_r    <= diff_sat;
          done_r  <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign y_out = y_r;

endmodule
